### hw/rtl/tima_pkg.sv
// ----------------------------------------------------------------------------
// tima_pkg
// Shared types and constants of the divider/counter timer peripheral:
// item and result words, sequencer state and control groups, rate table.
// ----------------------------------------------------------------------------
package tima_pkg;

	// item kinds
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	// register map
	localparam logic [1:0] REG_DIV = 2'd0;
	localparam logic [1:0] REG_CNT = 2'd1;
	localparam logic [1:0] REG_MOD = 2'd2;
	localparam logic [1:0] REG_CTL = 2'd3;

	// counter rate select codes
	localparam logic [1:0] RATE_1024 = 2'd0;
	localparam logic [1:0] RATE_16   = 2'd1;
	localparam logic [1:0] RATE_64   = 2'd2;
	localparam logic [1:0] RATE_256  = 2'd3;

	localparam int unsigned PRE_W       = 11;
	localparam logic [2:0]  RELOAD_WAIT = 3'd4;
	localparam logic [4:0]  CTL_PAD     = 5'b11111;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] reg_select;
		logic [7:0] write_data;
		logic [7:0] tick_cycles;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_interrupt;
	} result_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_CNT,
		SEQ_FIN
	} seq_state_t;

	// status into the sequencer
	typedef struct packed {
		logic accept;
		logic is_tick;
		logic enabled;
		logic unit_ge;
		logic out_free;
	} seq_stat_t;

	// controls out of the sequencer
	typedef struct packed {
		logic item_ready;
		logic sel_cnt;
		logic div_step;
		logic cnt_step;
		logic load_out;
	} seq_ctl_t;

	// counter prescale period for a rate code
	function automatic logic [PRE_W-1:0] rate_period(input logic [1:0] rate);
		logic [PRE_W-1:0] p;
		unique case (rate)
			RATE_16:  p = 11'd16;
			RATE_64:  p = 11'd64;
			RATE_256: p = 11'd256;
			default:  p = 11'd1024;
		endcase
		return p;
	endfunction

endpackage

### hw/rtl/div_tima_timer_peripheral.sv
// ----------------------------------------------------------------------------
// div_tima_timer_peripheral
// Timer peripheral with a free-running divider and a programmable counter
// with delayed modulo reload and interrupt.
//
//   channel   signals                             word
//   item      item_valid / item_ready / item      mode, reg_select, data, cycles
//   result    result_valid / result_ready / result read_data, timer_interrupt
//
// Read, write and unused words go from idle to the last state, where output stall holds them.
// A tick runs the divider state and, with the counter on, the counter state:
// D divider steps (sum / DIVIDER_PERIOD, at most 1 at the default period)
// and C counter steps (up to 16 at the fastest rate), one per cycle through
// the shared compare-subtract unit.
// item_ready is high only while the sequencer is idle.
// The result register holds its word until result_ready; the word after it
// finishes its work and waits in the last state while the register is full.
// All timer state clears on arst_n.
// ----------------------------------------------------------------------------
module div_tima_timer_peripheral #(
	parameter int MAX_TICK_CYCLES = 255,
	parameter int DIVIDER_PERIOD  = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tima_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output tima_pkg::result_t result
);

	localparam logic [7:0] MaxTick   = 8'(MAX_TICK_CYCLES);
	localparam logic [8:0] DivPeriod = 9'(DIVIDER_PERIOD);

	tima_pkg::seq_stat_t stat;
	tima_pkg::seq_ctl_t  ctl;

	logic [8:0]                 div_pre_q;
	logic [7:0]                 div_q;
	logic [7:0]                 cnt_q;
	logic [7:0]                 mod_q;
	logic [2:0]                 ctl_q;
	logic [tima_pkg::PRE_W-1:0] cnt_pre_q;
	logic                       pend_q;
	logic [2:0]                 delay_q;
	logic [7:0]                 rd_q;
	logic                       irq_q;
	logic                       out_valid_q;
	tima_pkg::result_t          out_q;

	logic [7:0]                 cycles;
	logic                       accept;
	logic                       fire;
	logic [7:0]                 rd_nx;
	logic [2:0]                 ctl_nx;
	logic                       pre_clr;
	logic [tima_pkg::PRE_W-1:0] unit_acc;
	logic [tima_pkg::PRE_W-1:0] unit_period;
	logic                       unit_ge;
	logic [tima_pkg::PRE_W-1:0] unit_rest;

	// saturate tick length
	assign cycles = (item.tick_cycles > MaxTick) ? MaxTick : item.tick_cycles;
	assign accept = item_valid && ctl.item_ready;

	// delayed reload fires when the tick covers the remaining wait
	assign fire = pend_q && (delay_q != 3'd0) && ({5'd0, delay_q} <= cycles);

	// register read mux
	always_comb begin
		unique case (item.reg_select)
			tima_pkg::REG_DIV: rd_nx = div_q;
			tima_pkg::REG_CNT: rd_nx = cnt_q;
			tima_pkg::REG_MOD: rd_nx = mod_q;
			default:           rd_nx = {tima_pkg::CTL_PAD, ctl_q};
		endcase
	end

	// control write: prescale clears on enable or on rate change while enabled
	assign ctl_nx  = item.write_data[2:0];
	assign pre_clr = ctl_nx[2] && (!ctl_q[2] || (ctl_q[1:0] != ctl_nx[1:0]));

	// shared unit operand select
	assign unit_acc    = ctl.sel_cnt ? cnt_pre_q : {2'b00, div_pre_q};
	assign unit_period = ctl.sel_cnt ? tima_pkg::rate_period(ctl_q[1:0])
	                                 : {2'b00, DivPeriod};

	tima_step u_step (
		.acc    (unit_acc),
		.period (unit_period),
		.ge     (unit_ge),
		.rest   (unit_rest)
	);

	// sequencer status
	always_comb begin
		stat.accept   = accept;
		stat.is_tick  = (item.mode == tima_pkg::MODE_TICK);
		stat.enabled  = ctl_q[2];
		stat.unit_ge  = unit_ge;
		stat.out_free = !out_valid_q || result_ready;
	end

	tima_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_pre_q <= '0;
			div_q     <= '0;
			cnt_q     <= '0;
			mod_q     <= '0;
			ctl_q     <= '0;
			cnt_pre_q <= '0;
			pend_q    <= 1'b0;
			delay_q   <= '0;
		end else if (accept) begin
			case (item.mode)
				tima_pkg::MODE_TICK: begin
					div_pre_q <= div_pre_q + {1'b0, cycles};
					if (pend_q && (delay_q != 3'd0)) begin
						if (fire) begin
							delay_q <= '0;
							cnt_q   <= mod_q;
							pend_q  <= 1'b0;
						end else begin
							delay_q <= delay_q - cycles[2:0];
						end
					end
					if (ctl_q[2]) begin
						cnt_pre_q <= cnt_pre_q + {3'b000, cycles};
					end
				end
				tima_pkg::MODE_WRITE: begin
					case (item.reg_select)
						tima_pkg::REG_DIV: begin
							div_q     <= '0;
							div_pre_q <= '0;
						end
						tima_pkg::REG_CNT: begin
							if (pend_q && (delay_q != 3'd0)) begin
								pend_q  <= 1'b0;
								delay_q <= '0;
							end
							cnt_q <= item.write_data;
						end
						tima_pkg::REG_MOD: mod_q <= item.write_data;
						default: begin
							ctl_q <= ctl_nx;
							if (pre_clr) begin
								cnt_pre_q <= '0;
							end
						end
					endcase
				end
				default: begin
				end
			endcase
		end else if (ctl.div_step) begin
			div_pre_q <= unit_rest[8:0];
			div_q     <= div_q + 8'd1;
		end else if (ctl.cnt_step) begin
			cnt_pre_q <= unit_rest;
			if (cnt_q == 8'hFF) begin
				cnt_q   <= '0;
				pend_q  <= 1'b1;
				delay_q <= tima_pkg::RELOAD_WAIT;
			end else begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	// result of the word in work
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q  <= (item.mode == tima_pkg::MODE_READ) ? rd_nx : 8'd0;
			irq_q <= (item.mode == tima_pkg::MODE_TICK) && fire;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q.read_data       <= rd_q;
			out_q.timer_interrupt <= irq_q;
		end
	end

	assign item_ready   = ctl.item_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### hw/rtl/tima_step.sv
// ----------------------------------------------------------------------------
// tima_step
// Shared compare-subtract unit: checks a prescale accumulator against a
// period and gives the remainder after one period is taken off.
// ----------------------------------------------------------------------------
module tima_step (
	input  logic [tima_pkg::PRE_W-1:0] acc,
	input  logic [tima_pkg::PRE_W-1:0] period,
	output logic                       ge,
	output logic [tima_pkg::PRE_W-1:0] rest
);

	// one compare and one subtract per cycle
	assign ge   = (acc >= period);
	assign rest = acc - period;

endmodule

### hw/rtl/tima_seq.sv
// ----------------------------------------------------------------------------
// tima_seq
// Sequencer: takes a word; for a tick it runs divider and, with the counter on, counter prescale
// steps through the shared unit one per cycle, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module tima_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  tima_pkg::seq_stat_t stat,
	output tima_pkg::seq_ctl_t  ctl
);

	tima_pkg::seq_state_t state_q;
	tima_pkg::seq_state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tima_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tima_pkg::SEQ_IDLE: begin
				if (stat.accept) begin
					state_nx = stat.is_tick ? tima_pkg::SEQ_DIV : tima_pkg::SEQ_FIN;
				end
			end
			tima_pkg::SEQ_DIV: begin
				if (!stat.unit_ge) begin
					state_nx = stat.enabled ? tima_pkg::SEQ_CNT : tima_pkg::SEQ_FIN;
				end
			end
			tima_pkg::SEQ_CNT: begin
				if (!stat.unit_ge) begin
					state_nx = tima_pkg::SEQ_FIN;
				end
			end
			tima_pkg::SEQ_FIN: begin
				if (stat.out_free) begin
					state_nx = tima_pkg::SEQ_IDLE;
				end
			end
			default: state_nx = tima_pkg::SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			tima_pkg::SEQ_IDLE: ctl.item_ready = 1'b1;
			tima_pkg::SEQ_DIV:  ctl.div_step   = stat.unit_ge;
			tima_pkg::SEQ_CNT: begin
				ctl.sel_cnt  = 1'b1;
				ctl.cnt_step = stat.unit_ge;
			end
			tima_pkg::SEQ_FIN:  ctl.load_out   = stat.out_free;
			default:            ctl            = '0;
		endcase
	end

endmodule
